/* src/pdp_pkg.sv */
// Shared types, constants and helpers for the point-to-segment projection block.
package pdp_pkg;

  localparam int CW  = 32;                 // coordinate width
  localparam int FB  = 16;                 // fraction bits
  localparam int QN  = CW + 1;             // quotient bits, top one flags overflow
  localparam int UUW = 2 * CW + 2;         // dot-product accumulator width
  localparam int NW  = UUW + FB + 2;       // dividend width
  localparam int DW  = UUW + 1;            // divisor width
  localparam int RW  = (NW > DW + CW) ? NW : DW + CW;  // remainder width

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   diff_t;
  typedef logic [CW:0]          mag_t;
  typedef logic [UUW-1:0]       acc_t;
  typedef logic [RW-1:0]        rem_t;
  typedef logic [DW-1:0]        dvs_t;
  typedef logic [QN-1:0]        quo_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t FRAC_ONE  = coord_t'(1) << FB;

  typedef enum logic [1:0] {
    OP_LINE_3D = 2'b00,
    OP_LINE_XY = 2'b01,
    OP_SEG_3D  = 2'b10
  } op_t;

  typedef enum logic [2:0] {
    MD_INTERP = 3'b001,
    MD_START  = 3'b010,
    MD_END    = 3'b100
  } mode_t;

  typedef struct packed {
    logic [1:0] operation;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     start_z;
    coord_t     end_x;
    coord_t     end_y;
    coord_t     end_z;
    coord_t     point_x;
    coord_t     point_y;
    coord_t     point_z;
  } in_t;

  typedef struct packed {
    coord_t fraction;
    coord_t closest_x;
    coord_t closest_y;
    coord_t closest_z;
    logic   ok;
  } out_t;

  // travels alongside the divider
  typedef struct packed {
    logic             bounded;
    logic             xy;
    logic             neg;
    logic             ok;
    coord_t [2:0]     s;
    diff_t  [2:0]     u;
  } sb_t;

  function automatic mag_t mag_of(diff_t x);
    return x[CW] ? mag_t'(-x) : mag_t'(x);
  endfunction

endpackage

/* src/pdp_div_cell.sv */
// One restoring-division cell: a single quotient bit per clock while en is high.
module pdp_div_cell #(
  parameter int SH = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  pdp_pkg::rem_t rem_i,
  input  pdp_pkg::dvs_t dvs_i,
  input  pdp_pkg::quo_t quo_i,
  input  pdp_pkg::sb_t  sb_i,
  output logic          vld_o,
  output pdp_pkg::rem_t rem_o,
  output pdp_pkg::dvs_t dvs_o,
  output pdp_pkg::quo_t quo_o,
  output pdp_pkg::sb_t  sb_o
);

  logic                    vld_r;
  pdp_pkg::rem_t           rem_r, rem_nxt;
  pdp_pkg::dvs_t           dvs_r;
  pdp_pkg::quo_t           quo_r, quo_nxt;
  pdp_pkg::sb_t            sb_r;
  pdp_pkg::rem_t           trial;
  logic [pdp_pkg::RW:0]    diff;
  logic                    take;

  assign trial   = pdp_pkg::rem_t'(dvs_i) << SH;
  assign diff    = {1'b0, rem_i} - {1'b0, trial};
  assign take    = ~diff[pdp_pkg::RW];
  assign rem_nxt = take ? diff[pdp_pkg::RW-1:0] : rem_i;
  assign quo_nxt = {quo_i[pdp_pkg::QN-2:0], take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_i;
      quo_r <= quo_nxt;
      sb_r  <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign quo_o = quo_r;
  assign sb_o  = sb_r;

endmodule

/* src/pdp_lane.sv */
// One axis of the closest point: fraction times span, rounding and saturation, or start or end point by mode.
module pdp_lane (
  input  logic            clk,
  input  logic            en,
  input  logic            ld,
  input  pdp_pkg::coord_t frac_i,
  input  pdp_pkg::coord_t start_i,
  input  pdp_pkg::diff_t  span_i,
  input  pdp_pkg::mode_t  mode_i,
  output pdp_pkg::coord_t coord_o
);

  localparam int CW = pdp_pkg::CW;
  localparam int FB = pdp_pkg::FB;
  localparam int PW = 2 * CW + 1;
  localparam int MW = PW + 1 - FB;

  logic [CW-1:0]         fmag;
  pdp_pkg::mag_t         umag;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic                  neg_r;
  pdp_pkg::coord_t       start_r, end_r;
  pdp_pkg::mode_t        mode_r;
  logic [PW:0]           rnd;
  logic [MW-1:0]         mq;
  logic                  big;
  logic signed [CW+1:0]  st_w, mq_w, wide_sum;
  pdp_pkg::coord_t       coord_r, coord_nxt;

  assign fmag     = frac_i[CW-1] ? CW'(-frac_i) : CW'(frac_i);
  assign umag     = pdp_pkg::mag_of(span_i);
  assign prod_nxt = PW'(fmag) * PW'(umag);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      neg_r   <= frac_i[CW-1] ^ span_i[CW];
      start_r <= start_i;
      end_r   <= start_i + pdp_pkg::coord_t'(span_i);
      mode_r  <= mode_i;
    end
  end

  // round half away from zero on the magnitude
  assign rnd      = {1'b0, prod_r} + ((PW+1)'(1) << (FB - 1));
  assign mq       = rnd[PW:FB];
  assign big      = mq > (MW'(1) << CW);
  assign st_w     = (CW+2)'(start_r);
  assign mq_w     = signed'({1'b0, mq[CW:0]});
  assign wide_sum = neg_r ? st_w - mq_w : st_w + mq_w;

  always_comb begin
    case (mode_r)
      pdp_pkg::MD_START: coord_nxt = start_r;
      pdp_pkg::MD_END:   coord_nxt = end_r;
      default: begin
        if (big) begin
          coord_nxt = neg_r ? pdp_pkg::COORD_MIN : pdp_pkg::COORD_MAX;
        end else if (wide_sum > (CW+2)'(pdp_pkg::COORD_MAX)) begin
          coord_nxt = pdp_pkg::COORD_MAX;
        end else if (wide_sum < (CW+2)'(pdp_pkg::COORD_MIN)) begin
          coord_nxt = pdp_pkg::COORD_MIN;
        end else begin
          coord_nxt = wide_sum[CW-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord_o = coord_r;

endmodule

/* src/point_to_segment_projection.sv */
// Pipeline: 5 front stages, 33 divider cells at one quotient bit each, then the
// fraction, multiply and output register stages.
// Throughput: one transaction per cycle; the whole pipeline holds only when the
// output register is full, not taken, and the last stage carries a result.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module point_to_segment_projection (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pdp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pdp_pkg::out_t out_data
);

  localparam int CW = pdp_pkg::CW;
  localparam int FB = pdp_pkg::FB;
  localparam int QN = pdp_pkg::QN;

  logic en, ld;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, vf_r, vm_r, out_valid_r;

  // stage 1: input register
  pdp_pkg::in_t in_r;

  // stage 2: differences
  pdp_pkg::coord_t [2:0] st, ep, pt;
  pdp_pkg::diff_t  [2:0] u_nxt, v_nxt, vd2_r;
  pdp_pkg::sb_t          sb2_nxt, sb2_r;

  // stage 3: products
  pdp_pkg::acc_t [2:0] uu3_nxt, uv3_nxt, uu3_r, uv3_r;
  logic          [2:0] sn3_nxt, sn3_r;
  pdp_pkg::sb_t        sb3_r;

  // stage 4: dot products
  pdp_pkg::acc_t uu4_nxt, uvp4_nxt, uvn4_nxt, uu4_r, uvp4_r, uvn4_r;
  pdp_pkg::sb_t  sb4_r;

  // stage 5: divider operands
  logic          neg5;
  pdp_pkg::acc_t m5;
  pdp_pkg::rem_t rem5_r;
  pdp_pkg::dvs_t dvs5_r;
  pdp_pkg::sb_t  sb5_nxt, sb5_r;

  // divider chain
  logic          vld_c [0:QN];
  pdp_pkg::rem_t rem_c [0:QN];
  pdp_pkg::dvs_t dvs_c [0:QN];
  pdp_pkg::quo_t quo_c [0:QN];
  pdp_pkg::sb_t  sb_c  [0:QN];

  // fraction stage
  pdp_pkg::quo_t   q_top;
  pdp_pkg::sb_t    sb_e;
  logic            huge, negq, satp;
  logic [CW-1:0]   qlo;
  pdp_pkg::coord_t frac_nxt, fracf_r, fracm_r, out_frac_r;
  pdp_pkg::mode_t  mode_nxt, modef_r;
  pdp_pkg::sb_t    sbf_r;
  logic            okm_r, out_ok_r;

  pdp_pkg::coord_t [2:0] closest;

  assign en       = out_ready | ~out_valid_r | ~vm_r;
  assign ld       = en & vm_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vf_r <= 1'b0;
      vm_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        v1_r <= in_valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        v5_r <= v4_r;
        vf_r <= vld_c[QN];
        vm_r <= vf_r;
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st = {in_r.start_z, in_r.start_y, in_r.start_x};
    ep = {in_r.end_z, in_r.end_y, in_r.end_x};
    pt = {in_r.point_z, in_r.point_y, in_r.point_x};
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = pdp_pkg::diff_t'(ep[i]) - pdp_pkg::diff_t'(st[i]);
      v_nxt[i] = pdp_pkg::diff_t'(pt[i]) - pdp_pkg::diff_t'(st[i]);
    end
    sb2_nxt         = '0;
    sb2_nxt.bounded = (in_r.operation != pdp_pkg::OP_LINE_3D) &&
                      (in_r.operation != pdp_pkg::OP_LINE_XY);
    sb2_nxt.xy      = (in_r.operation == pdp_pkg::OP_LINE_XY);
    sb2_nxt.s       = st;
    sb2_nxt.u       = u_nxt;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uu3_nxt[i] = pdp_pkg::acc_t'(pdp_pkg::mag_of(sb2_r.u[i])) *
                   pdp_pkg::acc_t'(pdp_pkg::mag_of(sb2_r.u[i]));
      uv3_nxt[i] = pdp_pkg::acc_t'(pdp_pkg::mag_of(sb2_r.u[i])) *
                   pdp_pkg::acc_t'(pdp_pkg::mag_of(vd2_r[i]));
      sn3_nxt[i] = sb2_r.u[i][CW] ^ vd2_r[i][CW];
    end
  end

  // xy operation drops z from both dot products
  always_comb begin
    uu4_nxt  = '0;
    uvp4_nxt = '0;
    uvn4_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (!(sb3_r.xy && i == 2)) begin
        uu4_nxt = uu4_nxt + uu3_r[i];
        if (sn3_r[i]) begin
          uvn4_nxt = uvn4_nxt + uv3_r[i];
        end else begin
          uvp4_nxt = uvp4_nxt + uv3_r[i];
        end
      end
    end
  end

  always_comb begin
    neg5        = uvp4_r < uvn4_r;
    m5          = neg5 ? uvn4_r - uvp4_r : uvp4_r - uvn4_r;
    sb5_nxt     = sb4_r;
    sb5_nxt.neg = neg5;
    sb5_nxt.ok  = (uu4_r != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r   <= in_data;
      vd2_r  <= v_nxt;
      sb2_r  <= sb2_nxt;
      uu3_r  <= uu3_nxt;
      uv3_r  <= uv3_nxt;
      sn3_r  <= sn3_nxt;
      sb3_r  <= sb2_r;
      uu4_r  <= uu4_nxt;
      uvp4_r <= uvp4_nxt;
      uvn4_r <= uvn4_nxt;
      sb4_r  <= sb3_r;
      // rounded quotient: (2m*2^FB + uu) / (2uu)
      rem5_r <= (pdp_pkg::rem_t'(m5) << (FB + 1)) + pdp_pkg::rem_t'(uu4_r);
      dvs5_r <= {uu4_r, 1'b0};
      sb5_r  <= sb5_nxt;
    end
  end

  assign vld_c[0] = v5_r;
  assign rem_c[0] = rem5_r;
  assign dvs_c[0] = dvs5_r;
  assign quo_c[0] = '0;
  assign sb_c[0]  = sb5_r;

  for (genvar g = 0; g < QN; g++) begin : g_cell
    pdp_div_cell #(
      .SH(CW - g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_c[g]),
      .rem_i (rem_c[g]),
      .dvs_i (dvs_c[g]),
      .quo_i (quo_c[g]),
      .sb_i  (sb_c[g]),
      .vld_o (vld_c[g+1]),
      .rem_o (rem_c[g+1]),
      .dvs_o (dvs_c[g+1]),
      .quo_o (quo_c[g+1]),
      .sb_o  (sb_c[g+1])
    );
  end

  always_comb begin
    q_top    = quo_c[QN];
    sb_e     = sb_c[QN];
    huge     = sb_e.ok & q_top[QN-1];
    qlo      = sb_e.ok ? q_top[CW-1:0] : '0;
    negq     = sb_e.ok & sb_e.neg;
    satp     = huge | qlo[CW-1];
    frac_nxt = '0;
    mode_nxt = pdp_pkg::MD_INTERP;
    if (sb_e.bounded) begin
      if (negq || (!huge && qlo == '0)) begin
        mode_nxt = pdp_pkg::MD_START;
      end else if (huge || qlo >= CW'(pdp_pkg::FRAC_ONE)) begin
        frac_nxt = pdp_pkg::FRAC_ONE;
        mode_nxt = pdp_pkg::MD_END;
      end else begin
        frac_nxt = pdp_pkg::coord_t'(qlo);
      end
    end else if (negq) begin
      frac_nxt = satp ? pdp_pkg::COORD_MIN : pdp_pkg::coord_t'(-qlo);
    end else begin
      frac_nxt = satp ? pdp_pkg::COORD_MAX : pdp_pkg::coord_t'(qlo);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fracf_r <= frac_nxt;
      modef_r <= mode_nxt;
      sbf_r   <= sb_e;
      fracm_r <= fracf_r;
      okm_r   <= sbf_r.ok;
    end
    if (ld) begin
      out_frac_r <= fracm_r;
      out_ok_r   <= okm_r;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane
    pdp_lane u_lane (
      .clk     (clk),
      .en      (en),
      .ld      (ld),
      .frac_i  (fracf_r),
      .start_i (sbf_r.s[a]),
      .span_i  (sbf_r.u[a]),
      .mode_i  (modef_r),
      .coord_o (closest[a])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_data.fraction  = out_frac_r;
  assign out_data.closest_x = closest[0];
  assign out_data.closest_y = closest[1];
  assign out_data.closest_z = closest[2];
  assign out_data.ok        = out_ok_r;

  a_ok_frac : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_frac_r == '0))
    else $error("degenerate segment with non-zero fraction");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && vm_r) |-> !in_ready)
    else $error("input taken while pipeline must hold");

  a_flow : assert property (@(posedge clk) disable iff (!rst_n)
    (vm_r && !out_valid_r) |=> out_valid_r)
    else $error("result lost between last stage and output register");

endmodule
